// ===== design/group_normalization_top_assert.svh =====
// assertion macros shared by the checker
`ifndef GROUP_NORMALIZATION_TOP_ASSERT_SVH
`define GROUP_NORMALIZATION_TOP_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off while in reset
`define GN_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/gn_pkg.sv =====
// ----------------------------------------------------------------------------
// gn_pkg
// Types and constants of the group normalization block.
// ----------------------------------------------------------------------------
package gn_pkg;

    localparam int DATA_W            = 16;
    localparam int CH_W              = 8;
    localparam int NUM_CHANNELS      = 256;
    localparam int MAX_GROUP_SAMPLES = 4096;
    localparam int CNT_W             = 13;
    localparam int SUM_W             = 32;
    localparam int SQ_W              = 48;
    localparam int INV_W             = 24;
    localparam int EPS_W             = 16;
    localparam int DIV_NUM_W         = 49;
    localparam int DIV_DEN_W         = 32;
    localparam int BIT_W             = 5;
    localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

    localparam logic [1:0] OP_COEF = 2'd0;
    localparam logic [1:0] OP_ACC  = 2'd1;
    localparam logic [1:0] OP_NORM = 2'd2;

    typedef struct packed {
        logic [1:0]               operation;
        logic [CH_W-1:0]          channel;
        logic signed [DATA_W-1:0] sample;
        logic signed [DATA_W-1:0] scale_coef;
        logic signed [DATA_W-1:0] bias_coef;
        logic                     last;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] normalized;
        logic                     saturated;
        logic                     end_of_group;
    } t_out_item;

    typedef enum logic [1:0] {
        DIV_MEAN,
        DIV_VAR,
        DIV_LIM
    } t_div_sel;

    typedef struct packed {
        logic     accept;
        logic     coef_wr;
        logic     acc_en;
        logic     div_start;
        t_div_sel div_sel;
        logic     mean_zero;
        logic     mean_load;
        logic     varq_load;
        logic     v_load;
        logic     inv_sat;
        logic     lim_load;
        logic     sqrt_step;
        logic     stats_set;
        logic     mul1;
        logic     mul2;
        logic     out_load;
        logic     clear;
    } t_dp_cmd;

    typedef struct packed {
        logic count_zero;
        logic stats_ready;
        logic div_done;
        logic v_zero;
        logic sqrt_last;
        logic out_free;
        logic item_last;
    } t_dp_status;

endpackage

// ===== design/gn_ram.sv =====
// ----------------------------------------------------------------------------
// gn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/gn_div.sv =====
// ----------------------------------------------------------------------------
// gn_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gn_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [gn_pkg::DIV_NUM_W-1:0]  i_num,
    input  logic [gn_pkg::DIV_DEN_W-1:0]  i_den,
    output logic                          o_done,
    output logic [gn_pkg::DIV_NUM_W-1:0]  o_quot,
    output logic [gn_pkg::DIV_DEN_W-1:0]  o_rem
);
    import gn_pkg::*;

    localparam int CNT_BITS = $clog2(DIV_NUM_W + 1);

    logic [DIV_NUM_W-1:0] r_q, n_q;
    logic [DIV_DEN_W-1:0] r_rem, n_rem, r_den;
    logic [CNT_BITS-1:0]  r_cnt;
    logic                 r_done;
    logic [DIV_DEN_W:0]   trial;
    logic                 fits;

    always_comb begin
        trial = {r_rem, r_q[DIV_NUM_W-1]};
        fits  = (trial >= {1'b0, r_den});
        n_rem = fits ? DIV_DEN_W'(trial - {1'b0, r_den}) : trial[DIV_DEN_W-1:0];
        n_q   = {r_q[DIV_NUM_W-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_BITS'(DIV_NUM_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule

// ===== design/gn_ctrl.sv =====
// ----------------------------------------------------------------------------
// gn_ctrl
// Sequencer: takes requests, runs group statistics and the normalize steps.
// ----------------------------------------------------------------------------
module gn_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [1:0]         i_operation,
    input  gn_pkg::t_dp_status i_status,
    output logic               o_stall,
    output gn_pkg::t_dp_cmd    o_cmd
);
    import gn_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MEAN,
        S_VAR,
        S_VSET,
        S_VCHK,
        S_LIM,
        S_SQRT,
        S_MUL1,
        S_MUL2,
        S_OUT
    } t_state;

    t_state  r_state, n_state;
    logic    r_stall;
    t_dp_cmd cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        cmd.div_sel = DIV_MEAN;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    cmd.accept = 1'b1;
                    case (i_operation)
                        OP_COEF: cmd.coef_wr = 1'b1;
                        OP_ACC:  cmd.acc_en  = 1'b1;
                        OP_NORM: begin
                            if (i_status.stats_ready) begin
                                n_state = S_MUL1;
                            end else if (i_status.count_zero) begin
                                cmd.mean_zero = 1'b1;
                                n_state = S_VSET;
                            end else begin
                                cmd.div_start = 1'b1;
                                cmd.div_sel   = DIV_MEAN;
                                n_state = S_MEAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_MEAN: begin
                if (i_status.div_done) begin
                    cmd.mean_load = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_VAR;
                    n_state = S_VAR;
                end
            end
            S_VAR: begin
                if (i_status.div_done) begin
                    cmd.varq_load = 1'b1;
                    n_state = S_VSET;
                end
            end
            S_VSET: begin
                cmd.v_load = 1'b1;
                n_state = S_VCHK;
            end
            S_VCHK: begin
                if (i_status.v_zero) begin
                    cmd.inv_sat   = 1'b1;
                    cmd.stats_set = 1'b1;
                    n_state = S_MUL1;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_LIM;
                    n_state = S_LIM;
                end
            end
            S_LIM: begin
                if (i_status.div_done) begin
                    cmd.lim_load = 1'b1;
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                cmd.sqrt_step = 1'b1;
                if (i_status.sqrt_last) begin
                    cmd.stats_set = 1'b1;
                    n_state = S_MUL1;
                end
            end
            S_MUL1: begin
                cmd.mul1 = 1'b1;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                cmd.mul2 = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.clear    = i_status.item_last;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stall <= 1'b0;
        end else begin
            r_state <= n_state;
            r_stall <= (n_state != S_IDLE);
        end
    end

    assign o_stall = r_stall;
    assign o_cmd   = cmd;

endmodule

// ===== design/gn_dp.sv =====
// ----------------------------------------------------------------------------
// gn_dp
// Datapath: accumulators, coefficient RAM, statistics and the result path.
// ----------------------------------------------------------------------------
module gn_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  gn_pkg::t_in_item            i_item,
    input  logic                        i_cfg_wr_en,
    input  logic [gn_pkg::EPS_W-1:0]    i_cfg_wr_data,
    input  gn_pkg::t_dp_cmd             i_cmd,
    input  logic                        i_stall,
    output gn_pkg::t_dp_status          o_status,
    output logic                        o_valid,
    output gn_pkg::t_out_item           o_result
);
    import gn_pkg::*;

    logic [EPS_W-1:0]         r_eps;
    t_in_item                 r_item;
    logic signed [SUM_W-1:0]  r_sum;
    logic [SQ_W-1:0]          r_sq;
    logic [CNT_W-1:0]         r_count;
    logic signed [DATA_W-1:0] r_mean;
    logic [2*DATA_W-1:0]      r_mean_sq;
    logic [DIV_NUM_W-1:0]     r_var_q;
    logic [DIV_DEN_W-1:0]     r_v;
    logic [DIV_NUM_W-1:0]     r_lim;
    logic [INV_W-1:0]         r_y;
    logic [BIT_W-1:0]         r_bit;
    logic                     r_ready;
    logic signed [32:0]       r_p1;
    logic signed [57:0]       r_p2;
    logic                     r_out_valid;
    t_out_item                r_out;

    logic [CH_W-1:0]          coef_raddr;
    logic [2*DATA_W-1:0]      coef_rdata;
    logic [DIV_NUM_W-1:0]     div_num;
    logic [DIV_DEN_W-1:0]     div_den;
    logic                     div_done;
    logic [DIV_NUM_W-1:0]     div_quot;
    logic [DIV_DEN_W-1:0]     div_rem;
    logic [SUM_W-1:0]         sum_mag;
    logic [16:0]              mean_mag;
    logic signed [16:0]       mean_s;
    logic signed [49:0]       var_s;
    logic [49:0]              var_c;
    logic [INV_W-1:0]         sq_t;
    logic [2*INV_W-1:0]       sq_p;
    logic signed [16:0]       diff;
    logic signed [33:0]       rnd;
    logic signed [34:0]       res;
    logic signed [DATA_W-1:0] bias;
    logic signed [2*DATA_W-1:0] x_sq;

    // read the new channel at the accept edge so the data is ready in the following cycle
    always_comb begin
        coef_raddr = i_cmd.accept ? i_item.channel : r_item.channel;
    end

    gn_ram #(
        .WIDTH (2*DATA_W),
        .DEPTH (NUM_CHANNELS)
    ) u_coef (
        .i_clk   (i_clk),
        .i_we    (i_cmd.coef_wr),
        .i_waddr (i_item.channel),
        .i_wdata ({i_item.scale_coef, i_item.bias_coef}),
        .i_raddr (coef_raddr),
        .o_rdata (coef_rdata)
    );

    // divider operand select
    always_comb begin
        sum_mag = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
        case (i_cmd.div_sel)
            DIV_MEAN: begin
                div_num = DIV_NUM_W'(sum_mag);
                div_den = DIV_DEN_W'(r_count);
            end
            DIV_VAR: begin
                div_num = DIV_NUM_W'(r_sq);
                div_den = DIV_DEN_W'(r_count);
            end
            DIV_LIM: begin
                div_num = DIV_NUM_W'(1) << (DIV_NUM_W - 1);
                div_den = r_v;
            end
            default: begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    gn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot),
        .o_rem   (div_rem)
    );

    always_comb begin
        // floor division: negative sums round away from zero on a remainder
        mean_mag = div_quot[16:0] + 17'((r_sum[SUM_W-1] && div_rem != '0) ? 1 : 0);
        mean_s   = r_sum[SUM_W-1] ? -$signed(mean_mag) : $signed(mean_mag);
        var_s    = $signed({1'b0, r_var_q}) - $signed({18'b0, r_mean_sq});
        var_c    = var_s[49] ? '0 : 50'(var_s);
        sq_t     = r_y | (INV_W'(1) << r_bit);
        sq_p     = sq_t * sq_t;
        diff     = $signed({r_item.sample[DATA_W-1], r_item.sample})
                   - $signed({r_mean[DATA_W-1], r_mean});
        bias     = $signed(coef_rdata[DATA_W-1:0]);
        rnd      = 34'((r_p2 + 58'sd8388608) >>> 24);
        res      = $signed({rnd[33], rnd}) + 35'(bias);
        x_sq     = i_item.sample * i_item.sample;
    end

    // configuration and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps       <= EPS_RESET;
            r_sum       <= '0;
            r_sq        <= '0;
            r_count     <= '0;
            r_mean      <= '0;
            r_y         <= '0;
            r_ready     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_eps <= i_cfg_wr_data;
            end
            if (i_cmd.acc_en && r_count < CNT_W'(MAX_GROUP_SAMPLES)) begin
                r_sum   <= r_sum + SUM_W'(i_item.sample);
                r_sq    <= r_sq + SQ_W'(unsigned'(x_sq));
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.mean_zero) begin
                r_mean <= '0;
            end else if (i_cmd.mean_load) begin
                r_mean <= mean_s[DATA_W-1:0];
            end
            if (i_cmd.inv_sat) begin
                r_y <= '1;
            end else if (i_cmd.lim_load) begin
                r_y <= '0;
            end else if (i_cmd.sqrt_step && {1'b0, sq_p} <= r_lim) begin
                r_y <= sq_t;
            end
            if (i_cmd.stats_set) begin
                r_ready <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.clear) begin
                r_sum   <= '0;
                r_sq    <= '0;
                r_count <= '0;
                r_mean  <= '0;
                r_y     <= '0;
                r_ready <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item <= i_item;
        end
        r_mean_sq <= unsigned'(32'(r_mean) * 32'(r_mean));
        if (i_cmd.mean_zero) begin
            r_var_q <= '0;
        end else if (i_cmd.varq_load) begin
            r_var_q <= div_quot;
        end
        if (i_cmd.v_load) begin
            r_v <= DIV_DEN_W'(var_c + 50'(r_eps));
        end
        if (i_cmd.lim_load) begin
            r_lim <= div_quot;
            r_bit <= BIT_W'(INV_W - 1);
        end else if (i_cmd.sqrt_step) begin
            r_bit <= r_bit - 1'b1;
        end
        if (i_cmd.mul1) begin
            r_p1 <= diff * $signed(coef_rdata[2*DATA_W-1:DATA_W]);
        end
        if (i_cmd.mul2) begin
            r_p2 <= r_p1 * $signed({1'b0, r_y});
        end
        if (i_cmd.out_load) begin
            r_out.end_of_group <= r_item.last;
            if (res > 35'sd32767) begin
                r_out.normalized <= 16'sh7FFF;
                r_out.saturated  <= 1'b1;
            end else if (res < -35'sd32768) begin
                r_out.normalized <= 16'sh8000;
                r_out.saturated  <= 1'b1;
            end else begin
                r_out.normalized <= res[DATA_W-1:0];
                r_out.saturated  <= 1'b0;
            end
        end
    end

    always_comb begin
        o_status.count_zero  = (r_count == '0);
        o_status.stats_ready = r_ready;
        o_status.div_done    = div_done;
        o_status.v_zero      = (r_v == '0);
        o_status.sqrt_last   = (r_bit == '0);
        o_status.out_free    = !r_out_valid || !i_stall;
        o_status.item_last   = r_item.last;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// ===== design/group_normalization_top.sv =====
// ----------------------------------------------------------------------------
// group_normalization_top
// Group normalization of Q8.8 samples with per-channel gain and offset.
// ----------------------------------------------------------------------------
// Coefficient and accumulate requests are taken without stalling the input.
// A normalize request runs through two registered multiplies and the
// output stage, which waits while a stalled result still holds the output
// register. The first normalize request of a group also computes the group
// statistics on one shared bit-serial divider (up to three divisions)
// followed by a 24-step inverse square root. A finished result waits in the
// output register while the next request is taken.
module group_normalization_top (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  gn_pkg::t_in_item         i_item,
    output logic                     o_valid,
    input  logic                     i_stall,
    output gn_pkg::t_out_item        o_result,
    input  logic                     i_cfg_wr_en,
    input  logic [gn_pkg::EPS_W-1:0] i_cfg_wr_data
);
    import gn_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    gn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_operation (i_item.operation),
        .i_status    (status),
        .o_stall     (o_stall),
        .o_cmd       (cmd)
    );

    gn_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (i_item),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (cmd),
        .i_stall       (i_stall),
        .o_status      (status),
        .o_valid       (o_valid),
        .o_result      (o_result)
    );

endmodule

// ===== design/gn_checker.sv =====
// ----------------------------------------------------------------------------
// gn_checker
// Port-level checks of the group normalization block, bound to the top.
// ----------------------------------------------------------------------------
`include "group_normalization_top_assert.svh"

module gn_checker (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_valid,
    input logic                     o_stall,
    input gn_pkg::t_in_item         i_item,
    input logic                     o_valid,
    input logic                     i_stall,
    input gn_pkg::t_out_item        o_result
);
    import gn_pkg::*;

    `GN_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid, "result dropped while stalled")
    `GN_ASSERT_NEXT(a_out_stable, o_valid && i_stall, $stable(o_result), "stalled result changed")
    `GN_ASSERT_NEXT(a_norm_busy, i_valid && !o_stall && i_item.operation == OP_NORM, o_stall, "normalize request did not start work")
    `GN_ASSERT_NEXT(a_other_free, i_valid && !o_stall && i_item.operation != OP_NORM, !o_stall, "non-normalize request stalled input")
    `GN_ASSERT(a_sat_value, o_valid && o_result.saturated, o_result.normalized == 16'sh7FFF || o_result.normalized == 16'sh8000, "saturated flag without limit value")

endmodule

bind group_normalization_top gn_checker u_gn_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .o_stall  (o_stall),
    .i_item   (i_item),
    .o_valid  (o_valid),
    .i_stall  (i_stall),
    .o_result (o_result)
);
